// File: design/alte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alte_pkg
// Shared constants and controller/datapath interface types for the array list
// table engine.
// ----------------------------------------------------------------------------
package alte_pkg;

  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;
  localparam int AMT_W = 16;
  localparam int BIT_W = $clog2(AMT_W);
  localparam int IN_W  = 64;
  localparam int OUT_W = 56;

  localparam logic [3:0] OP_GET   = 4'd0;
  localparam logic [3:0] OP_SET   = 4'd1;
  localparam logic [3:0] OP_PUSHB = 4'd2;
  localparam logic [3:0] OP_PUSHF = 4'd3;
  localparam logic [3:0] OP_INS   = 4'd4;
  localparam logic [3:0] OP_POP   = 4'd5;
  localparam logic [3:0] OP_FIND  = 4'd6;
  localparam logic [3:0] OP_FTR   = 4'd7;
  localparam logic [3:0] OP_ROTR  = 4'd8;
  localparam logic [3:0] OP_ROTL  = 4'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [1:0] WSEL_VAL = 2'd0;
  localparam logic [1:0] WSEL_MEM = 2'd1;
  localparam logic [1:0] WSEL_TMP = 2'd2;
  localparam logic [1:0] WSEL_SCR = 2'd3;

  typedef struct packed {
    logic             req_ld;
    logic             res_clr;
    logic             res_send;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [1:0]       mem_wsel;
    logic             scr_re;
    logic [AW-1:0]    scr_raddr;
    logic             scr_we;
    logic [AW-1:0]    scr_waddr;
    logic             tmp_ld;
    logic             vout_ld;
    logic             pos_ld;
    logic [AW-1:0]    pos;
    logic             status_ld;
    logic [2:0]       status;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             div_clr;
    logic             div_step;
    logic [BIT_W-1:0] div_bit;
  } cmd_t;

  typedef struct packed {
    logic [3:0]    op;
    logic [AW-1:0] idx;
    logic [CW-1:0] cnt;
    logic          match;
    logic [AW-1:0] k;
    logic          out_busy;
  } sts_t;

endpackage

// File: design/alte_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alte_datapath
// Element store, rotate scratch store, request and result registers, entry
// count, remainder unit and output register.
// ----------------------------------------------------------------------------
module alte_datapath import alte_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [IN_W-1:0]  in_data,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  logic [DW-1:0]    store [DEPTH];
  logic [DW-1:0]    scratch [DEPTH];
  logic [DW-1:0]    mem_rdata;
  logic [DW-1:0]    scr_rdata;
  logic [DW-1:0]    wdata;
  logic [3:0]       op;
  logic [AW-1:0]    idx;
  logic [DW-1:0]    val;
  logic [AMT_W-1:0] amt;
  logic [CW-1:0]    cnt;
  logic [DW-1:0]    tmp;
  logic [2:0]       status;
  logic [DW-1:0]    vout;
  logic [AW-1:0]    pos;
  logic [CW-1:0]    rem;
  logic [CW:0]      trial;

  always_comb begin
    case (cmd.mem_wsel)
      WSEL_VAL: wdata = val;
      WSEL_MEM: wdata = mem_rdata;
      WSEL_TMP: wdata = tmp;
      default:  wdata = scr_rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      store[cmd.mem_waddr] <= wdata;
    end
    if (cmd.mem_re) begin
      mem_rdata <= store[cmd.mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scr_we) begin
      scratch[cmd.scr_waddr] <= mem_rdata;
    end
    if (cmd.scr_re) begin
      scr_rdata <= scratch[cmd.scr_raddr];
    end
  end

  assign trial = {rem, amt[AMT_W - 1 - int'(cmd.div_bit)]};

  always_ff @(posedge clk) begin
    if (cmd.req_ld) begin
      op  <= in_data[3:0];
      idx <= in_data[11:4];
      val <= in_data[43:12];
      amt <= in_data[59:44];
    end
    if (cmd.tmp_ld) begin
      tmp <= mem_rdata;
    end
    if (cmd.div_clr) begin
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= (trial >= {1'b0, cnt}) ? CW'(trial - {1'b0, cnt}) : CW'(trial);
    end
    if (cmd.status_ld) begin
      status <= cmd.status;
    end else if (cmd.res_clr) begin
      status <= ST_OK;
    end
    if (cmd.vout_ld) begin
      vout <= mem_rdata;
    end else if (cmd.res_clr) begin
      vout <= '0;
    end
    if (cmd.pos_ld) begin
      pos <= cmd.pos;
    end else if (cmd.res_clr) begin
      pos <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_send) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_send) begin
      m_tdata <= {4'd0, cnt, pos, vout, status};
    end
  end

  assign sts.op       = op;
  assign sts.idx      = idx;
  assign sts.cnt      = cnt;
  assign sts.match    = (mem_rdata == val);
  assign sts.k        = rem[AW-1:0];
  assign sts.out_busy = m_tvalid & ~m_tready;

endmodule

// File: design/alte_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alte_controller
// Sequencer that walks the element store for each request and drives the
// datapath through command signals.
// ----------------------------------------------------------------------------
module alte_controller import alte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DECODE  = 5'd1;
  localparam logic [4:0] S_GET_CAP = 5'd2;
  localparam logic [4:0] S_SHUP_RD = 5'd3;
  localparam logic [4:0] S_SHUP_WR = 5'd4;
  localparam logic [4:0] S_POP_CAP = 5'd5;
  localparam logic [4:0] S_SHDN_RD = 5'd6;
  localparam logic [4:0] S_SHDN_WR = 5'd7;
  localparam logic [4:0] S_ROTL_CAP = 5'd8;
  localparam logic [4:0] S_FIND_RD = 5'd9;
  localparam logic [4:0] S_FIND_CMP = 5'd10;
  localparam logic [4:0] S_TR_CAP  = 5'd11;
  localparam logic [4:0] S_TR_WR   = 5'd12;
  localparam logic [4:0] S_DIV     = 5'd13;
  localparam logic [4:0] S_ROT_INIT = 5'd14;
  localparam logic [4:0] S_ROT_RD  = 5'd15;
  localparam logic [4:0] S_ROT_WR  = 5'd16;
  localparam logic [4:0] S_CPY_RD  = 5'd17;
  localparam logic [4:0] S_CPY_WR  = 5'd18;
  localparam logic [4:0] S_DONE    = 5'd19;

  logic [4:0]    state, state_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [AW-1:0] j, j_next;
  logic [AW-1:0] at, at_next;
  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] ptr_dec;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] j_inc;

  assign ptr_inc = ptr + CW'(1);
  assign ptr_dec = ptr - CW'(1);
  assign cnt_m1  = sts.cnt - CW'(1);
  assign j_inc   = {1'b0, j} + CW'(1);
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    j_next     = j;
    at_next    = at;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.req_ld = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.res_clr = 1'b1;
        state_next  = S_DONE;
        case (sts.op)
          OP_GET: begin
            if ({1'b0, sts.idx} < sts.cnt) begin
              cmd.mem_re    = 1'b1;
              cmd.mem_raddr = sts.idx;
              state_next    = S_GET_CAP;
            end else begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_RANGE;
            end
          end
          OP_SET: begin
            if ({1'b0, sts.idx} < sts.cnt) begin
              cmd.mem_we    = 1'b1;
              cmd.mem_waddr = sts.idx;
              cmd.mem_wsel  = WSEL_VAL;
            end else begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_RANGE;
            end
          end
          OP_PUSHB: begin
            if (sts.cnt >= CW'(DEPTH)) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_FULL;
            end else begin
              cmd.mem_we    = 1'b1;
              cmd.mem_waddr = sts.cnt[AW-1:0];
              cmd.mem_wsel  = WSEL_VAL;
              cmd.cnt_inc   = 1'b1;
            end
          end
          OP_PUSHF, OP_INS: begin
            if (sts.op == OP_INS && {1'b0, sts.idx} > sts.cnt) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_RANGE;
            end else if (sts.cnt >= CW'(DEPTH)) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_FULL;
            end else begin
              at_next    = (sts.op == OP_INS) ? sts.idx : '0;
              ptr_next   = sts.cnt;
              state_next = S_SHUP_RD;
            end
          end
          OP_POP: begin
            if (sts.cnt == '0) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_EMPTY;
            end else if ({1'b0, sts.idx} >= sts.cnt) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_RANGE;
            end else begin
              cmd.mem_re    = 1'b1;
              cmd.mem_raddr = sts.idx;
              ptr_next      = {1'b0, sts.idx};
              state_next    = S_POP_CAP;
            end
          end
          OP_FIND, OP_FTR: begin
            if (sts.cnt == '0) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_NOTFOUND;
            end else begin
              ptr_next   = '0;
              state_next = S_FIND_RD;
            end
          end
          OP_ROTR: begin
            if (sts.cnt == '0) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_EMPTY;
            end else begin
              cmd.div_clr = 1'b1;
              ptr_next    = '0;
              state_next  = S_DIV;
            end
          end
          OP_ROTL: begin
            if (sts.cnt == '0) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_EMPTY;
            end else begin
              cmd.mem_re    = 1'b1;
              cmd.mem_raddr = '0;
              ptr_next      = '0;
              state_next    = S_ROTL_CAP;
            end
          end
          default: begin
          end
        endcase
      end
      S_GET_CAP: begin
        cmd.vout_ld = 1'b1;
        state_next  = S_DONE;
      end
      S_SHUP_RD: begin
        if (ptr > {1'b0, at}) begin
          cmd.mem_re    = 1'b1;
          cmd.mem_raddr = ptr_dec[AW-1:0];
          state_next    = S_SHUP_WR;
        end else begin
          cmd.mem_we    = 1'b1;
          cmd.mem_waddr = at;
          cmd.mem_wsel  = WSEL_VAL;
          cmd.cnt_inc   = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_SHUP_WR: begin
        cmd.mem_we    = 1'b1;
        cmd.mem_waddr = ptr[AW-1:0];
        cmd.mem_wsel  = WSEL_MEM;
        ptr_next      = ptr_dec;
        state_next    = S_SHUP_RD;
      end
      S_POP_CAP: begin
        cmd.vout_ld = 1'b1;
        state_next  = S_SHDN_RD;
      end
      S_ROTL_CAP: begin
        cmd.tmp_ld = 1'b1;
        state_next = S_SHDN_RD;
      end
      S_SHDN_RD: begin
        if (ptr_inc < sts.cnt) begin
          cmd.mem_re    = 1'b1;
          cmd.mem_raddr = ptr_inc[AW-1:0];
          state_next    = S_SHDN_WR;
        end else begin
          if (sts.op == OP_POP) begin
            cmd.cnt_dec = 1'b1;
          end else begin
            cmd.mem_we    = 1'b1;
            cmd.mem_waddr = cnt_m1[AW-1:0];
            cmd.mem_wsel  = WSEL_TMP;
          end
          state_next = S_DONE;
        end
      end
      S_SHDN_WR: begin
        cmd.mem_we    = 1'b1;
        cmd.mem_waddr = ptr[AW-1:0];
        cmd.mem_wsel  = WSEL_MEM;
        ptr_next      = ptr_inc;
        state_next    = S_SHDN_RD;
      end
      S_FIND_RD: begin
        cmd.mem_re    = 1'b1;
        cmd.mem_raddr = ptr[AW-1:0];
        state_next    = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (sts.match) begin
          cmd.pos_ld = 1'b1;
          cmd.pos    = ptr[AW-1:0];
          if (sts.op == OP_FTR && ptr != '0) begin
            cmd.mem_re    = 1'b1;
            cmd.mem_raddr = ptr_dec[AW-1:0];
            state_next    = S_TR_CAP;
          end else begin
            state_next = S_DONE;
          end
        end else if (ptr_inc < sts.cnt) begin
          ptr_next   = ptr_inc;
          state_next = S_FIND_RD;
        end else begin
          cmd.status_ld = 1'b1;
          cmd.status    = ST_NOTFOUND;
          state_next    = S_DONE;
        end
      end
      S_TR_CAP: begin
        cmd.tmp_ld    = 1'b1;
        cmd.mem_we    = 1'b1;
        cmd.mem_waddr = ptr_dec[AW-1:0];
        cmd.mem_wsel  = WSEL_VAL;
        state_next    = S_TR_WR;
      end
      S_TR_WR: begin
        cmd.mem_we    = 1'b1;
        cmd.mem_waddr = ptr[AW-1:0];
        cmd.mem_wsel  = WSEL_TMP;
        cmd.pos_ld    = 1'b1;
        cmd.pos       = ptr_dec[AW-1:0];
        state_next    = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_bit  = ptr[BIT_W-1:0];
        if (ptr == CW'(AMT_W - 1)) begin
          state_next = S_ROT_INIT;
        end else begin
          ptr_next = ptr_inc;
        end
      end
      S_ROT_INIT: begin
        j_next     = sts.k;
        ptr_next   = '0;
        state_next = S_ROT_RD;
      end
      S_ROT_RD: begin
        cmd.mem_re    = 1'b1;
        cmd.mem_raddr = ptr[AW-1:0];
        state_next    = S_ROT_WR;
      end
      S_ROT_WR: begin
        cmd.scr_we    = 1'b1;
        cmd.scr_waddr = j;
        j_next        = (j_inc == sts.cnt) ? '0 : j_inc[AW-1:0];
        if (ptr_inc == sts.cnt) begin
          ptr_next   = '0;
          state_next = S_CPY_RD;
        end else begin
          ptr_next   = ptr_inc;
          state_next = S_ROT_RD;
        end
      end
      S_CPY_RD: begin
        cmd.scr_re    = 1'b1;
        cmd.scr_raddr = ptr[AW-1:0];
        state_next    = S_CPY_WR;
      end
      S_CPY_WR: begin
        cmd.mem_we    = 1'b1;
        cmd.mem_waddr = ptr[AW-1:0];
        cmd.mem_wsel  = WSEL_SCR;
        ptr_next      = ptr_inc;
        state_next    = (ptr_inc == sts.cnt) ? S_DONE : S_CPY_RD;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_send = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
      j     <= '0;
      at    <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      j     <= j_next;
      at    <= at_next;
    end
  end

endmodule

// File: design/array_list_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_table_engine
// Ordered list of up to 256 signed 32-bit words with get, set, push, insert,
// pop, find, find with transposition and rotate requests.
//
// Channel  Dir  Bits  Contents
// s_axis   in   64    op, index, value, rotate_amount
// m_axis   out  56    status, value_out, position, count
//
// One request at a time, one result per request. Insert and pop shift the
// entries between the index and the end one at a time, find scans the entries
// in order, and rotate right reduces the amount modulo the count and then copies
// the list through the scratch store and back. Reset clears the count; the store
// holds no defined contents. A stalled result waits in the output register; the
// next request is taken once the current result is in that register.
// ----------------------------------------------------------------------------
module array_list_table_engine import alte_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // op[3:0] index[11:4] value[43:12] rotate_amount[59:44]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status[2:0] value_out[34:3] position[42:35] count[51:43]
);

  cmd_t cmd;
  sts_t sts;

  alte_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  alte_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: design/alte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alte_checker
// Port-level checks for the array list table engine.
// ----------------------------------------------------------------------------
module alte_checker import alte_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_txn: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken before result");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ST_NOTFOUND)
    else $error("bad status code");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[51:43] <= 9'd256)
    else $error("count above capacity");

endmodule

bind array_list_table_engine alte_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: test/array_list_table_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_table_engine_test
// Drives list requests through the slave stream and checks every result on
// the master stream against a behavioral list kept in the bench. A directed
// table opens the run, then random request mixes with random stream idling.
// ----------------------------------------------------------------------------
module array_list_table_engine_test;
  import alte_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [7:0]  position;
    logic [8:0]  count;
  } list_result_t;

  typedef struct {
    logic [3:0]  op;
    logic [7:0]  index;
    logic [31:0] value;
    logic [15:0] amount;
    bit          typed;
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [8:0]  count;
  } list_row_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  logic [31:0]  model_words [DEPTH];
  int           model_count;
  list_result_t pending_results [$];
  int           errors;
  int           send_idle_pct;
  int           recv_idle_pct;
  logic [8:0]   typed_count [$];
  logic [2:0]   typed_status [$];
  logic [31:0]  typed_value [$];
  bit           typed_flag [$];
  list_row_t    directed_rows [$];

  array_list_table_engine DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("array_list_table_engine_test: FAIL");
    $finish;
  end

  function automatic list_result_t apply_request(logic [3:0] op, logic [7:0] idx,
                                                 logic [31:0] val, logic [15:0] amt);
    list_result_t r;
    logic [31:0]  scratch [DEPTH];
    logic [31:0]  t;
    int           k;
    int           hit;
    r.status = ST_OK;
    r.value_out = '0;
    r.position = '0;
    hit = -1;
    case (op)
      OP_GET: begin
        if (idx < model_count) r.value_out = model_words[idx];
        else r.status = ST_RANGE;
      end
      OP_SET: begin
        if (idx < model_count) model_words[idx] = val;
        else r.status = ST_RANGE;
      end
      OP_PUSHB, OP_PUSHF, OP_INS: begin
        k = (op == OP_PUSHB) ? model_count : (op == OP_PUSHF) ? 0 : idx;
        if (k > model_count) r.status = ST_RANGE;
        else if (model_count >= DEPTH) r.status = ST_FULL;
        else begin
          for (int i = model_count; i > k; i--) model_words[i] = model_words[i-1];
          model_words[k] = val;
          model_count++;
        end
      end
      OP_POP: begin
        if (model_count == 0) r.status = ST_EMPTY;
        else if (idx >= model_count) r.status = ST_RANGE;
        else begin
          r.value_out = model_words[idx];
          for (int i = idx; i + 1 < model_count; i++) model_words[i] = model_words[i+1];
          model_count--;
        end
      end
      OP_FIND, OP_FTR: begin
        for (int i = 0; i < model_count; i++)
          if (hit < 0 && model_words[i] == val) hit = i;
        if (hit < 0) r.status = ST_NOTFOUND;
        else if (op == OP_FTR && hit > 0) begin
          t = model_words[hit-1];
          model_words[hit-1] = model_words[hit];
          model_words[hit] = t;
          r.position = 8'(hit - 1);
        end else r.position = 8'(hit);
      end
      OP_ROTR: begin
        if (model_count == 0) r.status = ST_EMPTY;
        else begin
          k = amt % model_count;
          for (int i = 0; i < model_count; i++) scratch[(i + k) % model_count] = model_words[i];
          for (int i = 0; i < model_count; i++) model_words[i] = scratch[i];
        end
      end
      OP_ROTL: begin
        if (model_count == 0) r.status = ST_EMPTY;
        else begin
          t = model_words[0];
          for (int i = 0; i + 1 < model_count; i++) model_words[i] = model_words[i+1];
          model_words[model_count-1] = t;
        end
      end
      default: ;
    endcase
    r.count = 9'(model_count);
    return r;
  endfunction

  task automatic send_request(logic [3:0] op, logic [7:0] idx, logic [31:0] val,
                              logic [15:0] amt);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, amt, val, idx, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_request(op, idx, val, amt));
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
  end

  always @(posedge clk) begin
    list_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_tdata[2:0] !== e.status) begin
          $error("status expected %0d actual %0d", e.status, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[34:3] !== e.value_out) begin
          $error("value_out expected %h actual %h", e.value_out, m_tdata[34:3]);
          errors++;
        end
        if (m_tdata[42:35] !== e.position) begin
          $error("position expected %0d actual %0d", e.position, m_tdata[42:35]);
          errors++;
        end
        if (m_tdata[51:43] !== e.count) begin
          $error("count expected %0d actual %0d", e.count, m_tdata[51:43]);
          errors++;
        end
        if (typed_flag.size() > 0) begin
          if (typed_flag.pop_front()) begin
            if (e.status !== typed_status[0] || e.count !== typed_count[0] ||
                e.value_out !== typed_value[0]) begin
              $error("table row expected status %0d count %0d value %h, predicted %0d %0d %h",
                     typed_status[0], typed_count[0], typed_value[0],
                     e.status, e.count, e.value_out);
              errors++;
            end
            void'(typed_status.pop_front());
            void'(typed_count.pop_front());
            void'(typed_value.pop_front());
          end
        end
      end
    end
  end

  function automatic list_row_t row(logic [3:0] op, logic [7:0] idx, logic [31:0] val,
                                    logic [15:0] amt, bit typed, logic [2:0] st,
                                    logic [31:0] vo, logic [8:0] cnt);
    list_row_t r;
    r.op = op; r.index = idx; r.value = val; r.amount = amt;
    r.typed = typed; r.status = st; r.value_out = vo; r.count = cnt;
    return r;
  endfunction

  task automatic random_request();
    int          pick;
    logic [3:0]  op;
    logic [7:0]  idx;
    logic [31:0] val;
    pick = $urandom_range(99, 0);
    if (pick < 14) op = OP_PUSHB;
    else if (pick < 24) op = OP_PUSHF;
    else if (pick < 36) op = OP_INS;
    else if (pick < 50) op = OP_POP;
    else if (pick < 58) op = OP_GET;
    else if (pick < 66) op = OP_SET;
    else if (pick < 76) op = OP_FIND;
    else if (pick < 86) op = OP_FTR;
    else if (pick < 92) op = OP_ROTR;
    else if (pick < 97) op = OP_ROTL;
    else op = 4'($urandom_range(15, 10));
    if (model_count > 0 && $urandom_range(3, 0) != 0)
      idx = 8'($urandom_range(model_count, 0) % 256);
    else idx = 8'($urandom);
    if ((op == OP_FIND || op == OP_FTR) && model_count > 0 && $urandom_range(3, 0) != 0)
      val = model_words[$urandom_range(model_count - 1, 0)];
    else if ($urandom_range(1, 0)) val = $urandom_range(7, 0);
    else val = $urandom;
    send_request(op, idx, val, 16'($urandom));
  endtask

  initial begin
    errors = 0;
    model_count = 0;
    send_idle_pct = 27;
    recv_idle_pct = 63;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    directed_rows = '{
      row(OP_GET,   8'd0,   32'd0,        16'd0,     1, ST_RANGE,    32'd0, 9'd0),
      row(OP_POP,   8'd0,   32'd0,        16'd0,     1, ST_EMPTY,    32'd0, 9'd0),
      row(OP_FIND,  8'd0,   32'd0,        16'd0,     1, ST_NOTFOUND, 32'd0, 9'd0),
      row(OP_ROTR,  8'd0,   32'd0,        16'hFFFF,  1, ST_EMPTY,    32'd0, 9'd0),
      row(OP_ROTL,  8'd0,   32'd0,        16'd0,     1, ST_EMPTY,    32'd0, 9'd0),
      row(OP_INS,   8'd1,   32'd5,        16'd0,     1, ST_RANGE,    32'd0, 9'd0),
      row(OP_PUSHB, 8'd0,   32'h7FFFFFFF, 16'd0,     1, ST_OK,       32'd0, 9'd1),
      row(OP_PUSHF, 8'd0,   32'h80000000, 16'd0,     1, ST_OK,       32'd0, 9'd2),
      row(OP_INS,   8'd2,   32'hFFFFFFFF, 16'd0,     1, ST_OK,       32'd0, 9'd3),
      row(OP_INS,   8'd1,   32'd0,        16'd0,     0, 0, 0, 0),
      row(OP_GET,   8'd0,   32'd0,        16'd0,     1, ST_OK, 32'h80000000, 9'd4),
      row(OP_SET,   8'd255, 32'd1,        16'd0,     1, ST_RANGE,    32'd0, 9'd4),
      row(OP_SET,   8'd3,   32'd9,        16'd0,     0, 0, 0, 0),
      row(OP_FTR,   8'd0,   32'd9,        16'd0,     0, 0, 0, 0),
      row(OP_FTR,   8'd0,   32'h80000000, 16'd0,     0, 0, 0, 0),
      row(OP_FIND,  8'd0,   32'd1234,     16'd0,     0, 0, 0, 0),
      row(OP_ROTR,  8'd0,   32'd0,        16'hFFFF,  0, 0, 0, 0),
      row(OP_ROTR,  8'd0,   32'd0,        16'd4,     0, 0, 0, 0),
      row(OP_ROTL,  8'd0,   32'd0,        16'd0,     0, 0, 0, 0),
      row(4'hF,     8'hFF,  32'hFFFFFFFF, 16'hFFFF,  1, ST_OK,       32'd0, 9'd4),
      row(OP_POP,   8'd4,   32'd0,        16'd0,     1, ST_RANGE,    32'd0, 9'd4),
      row(OP_POP,   8'd0,   32'd0,        16'd0,     0, 0, 0, 0),
      row(OP_POP,   8'd2,   32'd0,        16'd0,     0, 0, 0, 0)
    };
    foreach (directed_rows[i]) begin
      typed_flag.push_back(directed_rows[i].typed);
      if (directed_rows[i].typed) begin
        typed_status.push_back(directed_rows[i].status);
        typed_count.push_back(directed_rows[i].count);
        typed_value.push_back(directed_rows[i].value_out);
      end
      send_request(directed_rows[i].op, directed_rows[i].index, directed_rows[i].value,
                   directed_rows[i].amount);
    end

    // fill to capacity, probe the full list, then drain
    while (model_count < DEPTH) send_request(OP_PUSHB, 8'd0, $urandom, 16'd0);
    send_request(OP_PUSHB, 8'd0, 32'd1, 16'd0);
    send_request(OP_PUSHF, 8'd0, 32'd1, 16'd0);
    send_request(OP_INS, 8'd255, 32'd1, 16'd0);
    send_request(OP_GET, 8'd255, 32'd0, 16'd0);
    send_request(OP_ROTR, 8'd0, 32'd0, 16'hFFFF);
    while (model_count > 0) send_request(OP_POP, 8'($urandom), 32'd0, 16'd0);

    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        send_idle_pct = 63;
        recv_idle_pct = 27;
      end else if (p == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (370) random_request();
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("array_list_table_engine_test: PASS");
    else $display("array_list_table_engine_test: FAIL");
    $finish;
  end
endmodule

// File: array_list_table_engine.f
design/alte_pkg.sv
design/alte_datapath.sv
design/alte_controller.sv
design/array_list_table_engine.sv
design/alte_checker.sv
test/array_list_table_engine_test.sv
